@@ hdl/ckm_pkg.sv @@
// ----------------------------------------------------------------------------
// ckm_pkg
// Shared widths, codes, state encoding and inter-module structs for the
// canonical k-mer window minimizer.
// ----------------------------------------------------------------------------
package ckm_pkg;

  localparam int MAX_KMER   = 31;
  localparam int MAX_WINDOW = 32;

  localparam int CODE_W  = 2 * MAX_KMER;               // packed k-mer code
  localparam int KLEN_W  = 5;                          // kmer_length register
  localparam int WLEN_W  = 6;                          // window_kmers register
  localparam int KCNT_W  = $clog2(MAX_KMER + 1);       // bases seen
  localparam int WIN_AW  = $clog2(MAX_WINDOW);         // window memory address
  localparam int WCNT_W  = $clog2(MAX_WINDOW + 1);     // k-mers in window
  localparam int POS_W   = 32;
  localparam int CHAR_W  = 7;
  localparam int CFG_DW  = 6;
  localparam int CFG_IW  = 1;

  localparam logic [POS_W-1:0] POS_MAX = '1;

  typedef enum logic [CFG_IW-1:0] {
    REG_KMER_LENGTH  = 1'b0,
    REG_WINDOW_KMERS = 1'b1
  } ckm_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CODE,
    S_WRITE,
    S_SCAN,
    S_DRAIN,
    S_EMIT
  } ckm_state_t;

  // sequencer to encoder
  typedef struct packed {
    logic              step;
    logic              start;
    logic              clr;
    logic [CHAR_W-1:0] base_char;
  } ckm_enc_ctl_t;

  // encoder to sequencer
  typedef struct packed {
    logic [CODE_W-1:0] fwd;
    logic [CODE_W-1:0] rev;
    logic              kmer_ok;
  } ckm_code_t;

endpackage

@@ hdl/ckm_if.sv @@
// ----------------------------------------------------------------------------
// ckm_in_if / ckm_out_if
// Valid/ready channels for base items and minimizer result items.
// ----------------------------------------------------------------------------
interface ckm_in_if;
  import ckm_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] base_char;
  logic              sequence_start;

  modport source (output valid, output base_char, output sequence_start, input ready);
  modport sink   (input valid, input base_char, input sequence_start, output ready);
endinterface

interface ckm_out_if;
  import ckm_pkg::*;

  logic              valid;
  logic              ready;
  logic [CODE_W-1:0] minimizer_value;
  logic [POS_W-1:0]  minimizer_position;

  modport source (output valid, output minimizer_value, output minimizer_position,
                  input ready);
  modport sink   (input valid, input minimizer_value, input minimizer_position,
                  output ready);
endinterface

@@ hdl/ckm_window_ram.sv @@
// ----------------------------------------------------------------------------
// ckm_window_ram
// Circular store of canonical k-mer codes, one write and one registered read.
// ----------------------------------------------------------------------------
module ckm_window_ram (
  input  logic                       clk,
  input  logic                       we,
  input  logic [ckm_pkg::WIN_AW-1:0] waddr,
  input  logic [ckm_pkg::CODE_W-1:0] wdata,
  input  logic [ckm_pkg::WIN_AW-1:0] raddr,
  output logic [ckm_pkg::CODE_W-1:0] rdata_r
);
  import ckm_pkg::*;

  logic [CODE_W-1:0] mem [MAX_WINDOW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

@@ hdl/ckm_kmer_code.sv @@
// ----------------------------------------------------------------------------
// ckm_kmer_code
// Rolling forward and reverse-complement codes of the last k bases.
// ----------------------------------------------------------------------------
module ckm_kmer_code (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [ckm_pkg::KCNT_W-1:0] k_eff,
  input  ckm_pkg::ckm_enc_ctl_t      ctl,
  output ckm_pkg::ckm_code_t         code
);
  import ckm_pkg::*;

  logic [CODE_W-1:0] fwd_r, fwd_nxt;
  logic [CODE_W-1:0] rev_r, rev_nxt;
  logic [KCNT_W-1:0] seen_r, seen_nxt;
  logic              ok_r, ok_nxt;

  logic [CODE_W-1:0] fwd_base, rev_base, mask, ins;
  logic [KCNT_W-1:0] seen_base;
  logic [1:0]        fwd2, comp2;
  logic [5:0]        sh;

  function automatic logic [1:0] fwd_of(input logic [CHAR_W-1:0] c);
    logic [1:0] r;
    r = 2'd0;
    case ({1'b0, c})
      "C", "c": r = 2'd1;
      "G", "g": r = 2'd2;
      "T", "t": r = 2'd3;
      default:  r = 2'd0;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] comp_of(input logic [CHAR_W-1:0] c);
    logic [1:0] r;
    r = 2'd0;
    case ({1'b0, c})
      "A", "a": r = 2'd3;
      "C", "c": r = 2'd2;
      "G", "g": r = 2'd1;
      default:  r = 2'd0;
    endcase
    return r;
  endfunction

  always_comb begin
    for (int i = 0; i < CODE_W; i++) begin
      mask[i] = (KCNT_W'(i >> 1) < k_eff);
    end
    fwd2      = fwd_of(ctl.base_char);
    comp2     = comp_of(ctl.base_char);
    sh        = {k_eff - KCNT_W'(1), 1'b0};
    ins       = {{(CODE_W-2){1'b0}}, comp2} << sh;
    // a sequence start clears history before this base goes in
    fwd_base  = ctl.start ? '0 : fwd_r;
    rev_base  = ctl.start ? '0 : rev_r;
    seen_base = ctl.start ? '0 : seen_r;

    fwd_nxt  = fwd_r;
    rev_nxt  = rev_r;
    seen_nxt = seen_r;
    ok_nxt   = ok_r;
    if (ctl.clr) begin
      fwd_nxt  = '0;
      rev_nxt  = '0;
      seen_nxt = '0;
      ok_nxt   = 1'b0;
    end else if (ctl.step) begin
      fwd_nxt  = {fwd_base[CODE_W-3:0], fwd2} & mask;
      rev_nxt  = ((rev_base >> 2) | ins) & mask;
      seen_nxt = (seen_base < k_eff) ? seen_base + KCNT_W'(1) : seen_base;
      ok_nxt   = (seen_nxt >= k_eff);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r  <= '0;
      rev_r  <= '0;
      seen_r <= '0;
      ok_r   <= 1'b0;
    end else begin
      fwd_r  <= fwd_nxt;
      rev_r  <= rev_nxt;
      seen_r <= seen_nxt;
      ok_r   <= ok_nxt;
    end
  end

  assign code.fwd     = fwd_r;
  assign code.rev     = rev_r;
  assign code.kmer_ok = ok_r;

endmodule

@@ hdl/ckm_seq.sv @@
// ----------------------------------------------------------------------------
// ckm_seq
// Item sequencer: window write, scan with one shared comparator, result
// register.
// ----------------------------------------------------------------------------
module ckm_seq (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_clr,
  input  logic [ckm_pkg::WCNT_W-1:0] w_eff,
  ckm_in_if.sink                     in_ch,
  ckm_out_if.source                  out_ch,
  input  ckm_pkg::ckm_code_t         code,
  output ckm_pkg::ckm_enc_ctl_t      enc_ctl
);
  import ckm_pkg::*;

  ckm_state_t        state_r, state_nxt;
  logic [CHAR_W-1:0] char_r;
  logic              start_r;
  logic [WIN_AW-1:0] head_r, head_nxt;
  logic [WCNT_W-1:0] kiw_r, kiw_nxt;
  logic [POS_W-1:0]  cnt_r, cnt_nxt;
  logic [POS_W-1:0]  newest_r, newest_nxt;
  logic [POS_W-1:0]  last_r, last_nxt;
  logic              emitted_r, emitted_nxt;
  logic [WIN_AW-1:0] scan_j_r, scan_j_nxt;
  logic              rd_vld_r, rd_vld_nxt;
  logic              rd_first_r, rd_first_nxt;
  logic [WIN_AW-1:0] rd_age_r, rd_age_nxt;
  logic [CODE_W-1:0] best_r, best_nxt;
  logic [WIN_AW-1:0] best_age_r, best_age_nxt;
  logic              out_vld_r, out_vld_nxt;
  logic [CODE_W-1:0] out_val_r, out_val_nxt;
  logic [POS_W-1:0]  out_pos_r, out_pos_nxt;

  logic              we;
  logic [WIN_AW-1:0] raddr;
  logic [CODE_W-1:0] rdata, canon, cmp_a, cmp_b;
  logic              lt, seq_clr, load;
  logic [WIN_AW-1:0] w_m1;
  logic [POS_W-1:0]  pos;

  ckm_window_ram u_ram (
    .clk     (clk),
    .we      (we),
    .waddr   (head_nxt),
    .wdata   (canon),
    .raddr   (raddr),
    .rdata_r (rdata)
  );

  // shared comparator: canonical pick while writing, running minimum otherwise
  assign cmp_a = (state_r == S_WRITE) ? code.fwd : rdata;
  assign cmp_b = (state_r == S_WRITE) ? code.rev : best_r;
  assign lt    = (cmp_a < cmp_b);
  assign canon = lt ? code.fwd : code.rev;

  assign w_m1  = WIN_AW'(w_eff - WCNT_W'(1));
  assign raddr = head_r - scan_j_r;
  assign pos   = newest_r - POS_W'(best_age_r);

  assign in_ch.ready             = (state_r == S_IDLE);
  assign out_ch.valid            = out_vld_r;
  assign out_ch.minimizer_value    = out_val_r;
  assign out_ch.minimizer_position = out_pos_r;

  assign enc_ctl.step      = (state_r == S_CODE);
  assign enc_ctl.start     = start_r;
  assign enc_ctl.clr       = cfg_clr;
  assign enc_ctl.base_char = char_r;

  always_comb begin
    state_nxt    = state_r;
    head_nxt     = head_r;
    kiw_nxt      = kiw_r;
    cnt_nxt      = cnt_r;
    newest_nxt   = newest_r;
    last_nxt     = last_r;
    emitted_nxt  = emitted_r;
    scan_j_nxt   = scan_j_r;
    rd_vld_nxt   = 1'b0;
    rd_first_nxt = 1'b0;
    rd_age_nxt   = scan_j_r;
    best_nxt     = best_r;
    best_age_nxt = best_age_r;
    out_vld_nxt  = out_vld_r && !out_ch.ready;
    out_val_nxt  = out_val_r;
    out_pos_nxt  = out_pos_r;
    we           = 1'b0;
    load         = 1'b0;
    seq_clr      = cfg_clr || (state_r == S_CODE && start_r);

    // fold the read that landed this cycle into the running minimum
    if (rd_vld_r && (rd_first_r || lt)) begin
      best_nxt     = rdata;
      best_age_nxt = rd_age_r;
    end

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          state_nxt = S_CODE;
        end
      end
      S_CODE: begin
        state_nxt = S_WRITE;
      end
      S_WRITE: begin
        if (!code.kmer_ok) begin
          state_nxt = S_IDLE;
        end else begin
          we         = 1'b1;
          head_nxt   = head_r + WIN_AW'(1);
          newest_nxt = cnt_r;
          if (cnt_r != POS_MAX) begin
            cnt_nxt = cnt_r + POS_W'(1);
          end
          if (kiw_r < w_eff) begin
            kiw_nxt = kiw_r + WCNT_W'(1);
          end
          if (kiw_nxt < w_eff) begin
            state_nxt = S_IDLE;
          end else begin
            scan_j_nxt = w_m1;
            state_nxt  = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        // oldest first, so strict less keeps the earliest on ties
        rd_vld_nxt   = 1'b1;
        rd_first_nxt = (scan_j_r == w_m1);
        if (scan_j_r == '0) begin
          state_nxt = S_DRAIN;
        end else begin
          scan_j_nxt = scan_j_r - WIN_AW'(1);
        end
      end
      S_DRAIN: begin
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (emitted_r && pos == last_r) begin
          state_nxt = S_IDLE;
        end else if (!out_vld_r || out_ch.ready) begin
          load        = 1'b1;
          out_vld_nxt = 1'b1;
          out_val_nxt = best_r;
          out_pos_nxt = pos;
          last_nxt    = pos;
          emitted_nxt = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (seq_clr) begin
      kiw_nxt     = '0;
      cnt_nxt     = '0;
      last_nxt    = '0;
      emitted_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      head_r     <= '0;
      kiw_r      <= '0;
      cnt_r      <= '0;
      newest_r   <= '0;
      last_r     <= '0;
      emitted_r  <= 1'b0;
      scan_j_r   <= '0;
      rd_vld_r   <= 1'b0;
      rd_first_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      head_r     <= head_nxt;
      kiw_r      <= kiw_nxt;
      cnt_r      <= cnt_nxt;
      newest_r   <= newest_nxt;
      last_r     <= last_nxt;
      emitted_r  <= emitted_nxt;
      scan_j_r   <= scan_j_nxt;
      rd_vld_r   <= rd_vld_nxt;
      rd_first_r <= rd_first_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      char_r  <= in_ch.base_char;
      start_r <= in_ch.sequence_start;
    end
    rd_age_r   <= rd_age_nxt;
    best_r     <= best_nxt;
    best_age_r <= best_age_nxt;
    out_val_r  <= out_val_nxt;
    out_pos_r  <= out_pos_nxt;
  end

  a_ready_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> (state_r == S_IDLE && !rd_vld_r))
    else $error("input taken while an item is in flight");

  a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_vld_r) |-> $past(state_r == S_EMIT))
    else $error("result raised outside the emit step");

  a_scan_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (scan_j_r <= w_m1 && kiw_r == w_eff))
    else $error("scan reaches past the filled window");

  a_emit_tracks_last: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> (emitted_r && last_r == out_pos_r && out_vld_r))
    else $error("last emitted position not tracking result");

endmodule

@@ hdl/canonical_kmer_window_minimizer_core.sv @@
// ----------------------------------------------------------------------------
// canonical_kmer_window_minimizer_core
// Canonical k-mer minimizer over a sliding window of k-mers.
//
//   channel  | dir | handshake           | payload
//   ---------+-----+---------------------+-------------------------------------
//   in_ch    | in  | valid/ready         | base_char[6:0], sequence_start
//   out_ch   | out | valid/ready         | minimizer_value[61:0],
//            |     |                     | minimizer_position[31:0]
//   cfg_*    | in  | cfg_we, no stall    | cfg_index[0], cfg_wdata[5:0]
//
// A base that completes a window steps through code, write, scan, drain and
// emit; a warm-up base only through code and write. The scan reads the window
// memory through its single read port, one entry a cycle into one shared
// comparator. Reset (rst_n, synchronous) and any register write clear the
// sequence state. in_ch.ready is high only between items; a pending result in
// the output register does not hold off the next base, only the next result.
// ----------------------------------------------------------------------------
module canonical_kmer_window_minimizer_core (
  input  logic                       clk,
  input  logic                       rst_n,
  ckm_in_if.sink                     in_ch,
  ckm_out_if.source                  out_ch,
  input  logic                       cfg_we,
  input  logic [ckm_pkg::CFG_IW-1:0] cfg_index,
  input  logic [ckm_pkg::CFG_DW-1:0] cfg_wdata
);
  import ckm_pkg::*;

  logic [KLEN_W-1:0] klen_r, klen_nxt;
  logic [WLEN_W-1:0] wlen_r, wlen_nxt;
  logic [KCNT_W-1:0] k_eff;
  logic [WCNT_W-1:0] w_eff;
  logic              cfg_clr;
  ckm_enc_ctl_t      enc_ctl;
  ckm_code_t         code;

  always_comb begin
    klen_nxt = klen_r;
    wlen_nxt = wlen_r;
    cfg_clr  = 1'b0;
    if (cfg_we) begin
      case (ckm_reg_t'(cfg_index))
        REG_KMER_LENGTH: begin
          klen_nxt = cfg_wdata[KLEN_W-1:0];
          cfg_clr  = 1'b1;
        end
        REG_WINDOW_KMERS: begin
          wlen_nxt = cfg_wdata[WLEN_W-1:0];
          cfg_clr  = 1'b1;
        end
        default: begin
          cfg_clr = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      klen_r <= KLEN_W'(15);
      wlen_r <= WLEN_W'(10);
    end else begin
      klen_r <= klen_nxt;
      wlen_r <= wlen_nxt;
    end
  end

  // clamp lengths into the supported range
  always_comb begin
    if (klen_r == '0) begin
      k_eff = KCNT_W'(1);
    end else if (32'(klen_r) > MAX_KMER) begin
      k_eff = KCNT_W'(MAX_KMER);
    end else begin
      k_eff = KCNT_W'(klen_r);
    end
    if (wlen_r == '0) begin
      w_eff = WCNT_W'(1);
    end else if (32'(wlen_r) > MAX_WINDOW) begin
      w_eff = WCNT_W'(MAX_WINDOW);
    end else begin
      w_eff = WCNT_W'(wlen_r);
    end
  end

  ckm_kmer_code u_code (
    .clk   (clk),
    .rst_n (rst_n),
    .k_eff (k_eff),
    .ctl   (enc_ctl),
    .code  (code)
  );

  ckm_seq u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_clr (cfg_clr),
    .w_eff   (w_eff),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .code    (code),
    .enc_ctl (enc_ctl)
  );

endmodule

@@ dv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for canonical_kmer_window_minimizer_core. A local
// predictor tracks the forward and reverse-complement codes and the window
// of canonical k-mers. It queues the minimizer that each accepted base
// should produce. A checker compares every result item against the oldest
// queued minimizer. Directed checks cover reset settings, base encoding,
// ties, sequence restarts and a long output hold-off. Random phases sweep the
// register settings, with random idling on both channels.
// ----------------------------------------------------------------------------
module testbench;
  import ckm_pkg::*;

  localparam int       SETTLE_CYCLES = 48;
  localparam longint   RUN_LIMIT     = 64'd20_000_000;
  localparam int       RANDOM_ITEMS  = 1060;

  typedef struct packed {
    logic [CODE_W-1:0] value;
    logic [POS_W-1:0]  position;
  } minimizer_t;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [CFG_IW-1:0] cfg_index;
  logic [CFG_DW-1:0] cfg_wdata;

  ckm_in_if  in_ch ();
  ckm_out_if out_ch ();

  canonical_kmer_window_minimizer_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // predictor state
  logic [KLEN_W-1:0] kmer_len_reg = 5'd15;
  logic [WLEN_W-1:0] window_reg   = 6'd10;
  logic [63:0]       fwd_state    = '0;
  logic [63:0]       rev_state    = '0;
  int unsigned       bases_taken  = 0;
  int unsigned       kmers_held   = 0;
  logic [POS_W-1:0]  next_kmer_index = '0;
  logic [POS_W-1:0]  last_position   = '0;
  bit                emitted_yet     = 0;
  logic [CODE_W-1:0] window_hist [MAX_WINDOW];

  minimizer_t expected_minimizers [$];
  minimizer_t oldest_expected;
  int         error_count = 0;

  bit sender_gaps_on     = 1;
  bit receiver_stalls_on = 1;
  int hold_off_request   = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #(RUN_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  function automatic void clear_sequence_model();
    fwd_state       = '0;
    rev_state       = '0;
    bases_taken     = 0;
    kmers_held      = 0;
    next_kmer_index = '0;
    last_position   = '0;
    emitted_yet     = 0;
  endfunction

  // Advance the predictor by one base; returns 1 when a minimizer is due.
  function automatic bit step_minimizer(input logic [CHAR_W-1:0] ch, input logic start,
                                        output minimizer_t found);
    int unsigned       k;
    int unsigned       w;
    int unsigned       best_idx;
    int                j;
    logic [63:0]       span_mask;
    logic [63:0]       fwd_bits;
    logic [63:0]       cmp_bits;
    logic [CODE_W-1:0] best;
    logic [POS_W-1:0]  newest;
    logic [POS_W-1:0]  pos;
    found = '0;
    if (start) clear_sequence_model();
    k = (kmer_len_reg == 0) ? 1 : kmer_len_reg;
    w = (window_reg == 0) ? 1 : (window_reg > MAX_WINDOW) ? MAX_WINDOW : window_reg;
    span_mask = (64'd1 << (2 * k)) - 64'd1;
    case ({1'b0, ch})
      "C", "c": begin fwd_bits = 64'd1; cmp_bits = 64'd2; end
      "G", "g": begin fwd_bits = 64'd2; cmp_bits = 64'd1; end
      "T", "t": begin fwd_bits = 64'd3; cmp_bits = 64'd0; end
      "A", "a": begin fwd_bits = 64'd0; cmp_bits = 64'd3; end
      default:  begin fwd_bits = 64'd0; cmp_bits = 64'd0; end
    endcase
    fwd_state = ((fwd_state << 2) | fwd_bits) & span_mask;
    rev_state = ((rev_state >> 2) | (cmp_bits << (2 * k - 2))) & span_mask;
    if (bases_taken < k) bases_taken++;
    if (bases_taken < k) return 0;

    for (j = MAX_WINDOW - 1; j > 0; j--) window_hist[j] = window_hist[j-1];
    window_hist[0] = (fwd_state < rev_state) ? fwd_state[CODE_W-1:0]
                                             : rev_state[CODE_W-1:0];
    newest = next_kmer_index;
    if (next_kmer_index != POS_MAX) next_kmer_index++;
    if (kmers_held < w) kmers_held++;
    if (kmers_held < w) return 0;

    // oldest entry first; strict less keeps the earliest on ties
    best_idx = w - 1;
    best     = window_hist[best_idx];
    for (j = int'(w) - 2; j >= 0; j--) begin
      if (window_hist[j] < best) begin
        best     = window_hist[j];
        best_idx = j;
      end
    end
    pos = newest - best_idx;
    if (emitted_yet && pos == last_position) return 0;
    emitted_yet    = 1;
    last_position  = pos;
    found.value    = best;
    found.position = pos;
    return 1;
  endfunction

  // Leaves valid high on return so back-to-back items need no second assignment.
  task automatic send_base(input logic [CHAR_W-1:0] ch, input logic start);
    int         gap;
    minimizer_t due;
    gap = sender_gaps_on ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.base_char      <= ch;
    in_ch.sequence_start <= start;
    do @(posedge clk); while (!in_ch.ready);
    if (step_minimizer(ch, start, due)) begin
      expected_minimizers.insert(expected_minimizers.size(), due);
    end
  endtask

  task automatic wait_until_drained();
    in_ch.valid <= 1'b0;
    while (expected_minimizers.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apply_settings(input logic [CFG_DW-1:0] k_data,
                                input logic [CFG_DW-1:0] w_data);
    wait_until_drained();
    cfg_we    <= 1'b1;
    cfg_index <= REG_KMER_LENGTH;
    cfg_wdata <= k_data;
    @(posedge clk);
    cfg_index <= REG_WINDOW_KMERS;
    cfg_wdata <= w_data;
    @(posedge clk);
    cfg_we <= 1'b0;
    kmer_len_reg = k_data[KLEN_W-1:0];
    window_reg   = w_data[WLEN_W-1:0];
    clear_sequence_model();
  endtask

  // Mostly ACGT in either case; a few raw characters as noise.
  function automatic logic [CHAR_W-1:0] draw_base(input bit two_letter);
    logic [CHAR_W-1:0] ch;
    if ($urandom_range(0, 99) < 6) return CHAR_W'($urandom_range(0, 127));
    case (two_letter ? $urandom_range(0, 1) : $urandom_range(0, 3))
      0:       ch = CHAR_W'("A");
      1:       ch = CHAR_W'("C");
      2:       ch = CHAR_W'("G");
      default: ch = CHAR_W'("T");
    endcase
    if ($urandom_range(0, 1)) ch = ch | 7'h20;
    return ch;
  endfunction

  task automatic test_reset_settings();
    repeat (30) send_base(draw_base(0), 1'b0);
  endtask

  task automatic test_base_encoding();
    // zero in both registers acts as one
    apply_settings(6'h00, 6'h00);
    send_base(CHAR_W'("A"), 1'b0);
    send_base(CHAR_W'("C"), 1'b0);
    send_base(CHAR_W'("G"), 1'b0);
    send_base(CHAR_W'("T"), 1'b0);
    send_base(CHAR_W'("a"), 1'b0);
    send_base(CHAR_W'("c"), 1'b0);
    send_base(CHAR_W'("g"), 1'b0);
    send_base(CHAR_W'("t"), 1'b0);
    send_base(7'h00, 1'b0);
    send_base(7'h7F, 1'b0);
    send_base(CHAR_W'("N"), 1'b0);
    send_base(CHAR_W'("U"), 1'b0);
  endtask

  task automatic test_ties_and_restart();
    // bit 5 of the k-mer write is dropped: k = 2
    apply_settings(6'h22, 6'h03);
    repeat (5) send_base(CHAR_W'("A"), 1'b0);
    send_base(CHAR_W'("C"), 1'b1);
    send_base(CHAR_W'("G"), 1'b0);
    send_base(CHAR_W'("T"), 1'b0);
    send_base(CHAR_W'("A"), 1'b0);
    send_base(CHAR_W'("t"), 1'b0);
  endtask

  task automatic test_output_holdoff();
    apply_settings(6'h01, 6'h01);
    sender_gaps_on     = 0;
    receiver_stalls_on = 0;
    hold_off_request   = 300;
    repeat (40) send_base(draw_base(0), 1'b0);
    wait_until_drained();
    sender_gaps_on     = 1;
    receiver_stalls_on = 1;
  endtask

  task automatic run_phase(input logic [CFG_DW-1:0] k_data, input logic [CFG_DW-1:0] w_data,
                           input int count);
    bit two_letter;
    int n;
    apply_settings(k_data, w_data);
    two_letter         = ($urandom_range(0, 3) == 0);
    sender_gaps_on     = ($urandom_range(0, 3) != 0);
    receiver_stalls_on = ($urandom_range(0, 3) != 0);
    for (n = 0; n < count; n++) begin
      // pause now and then until every pending result is out
      if ($urandom_range(0, 63) == 0) wait_until_drained();
      send_base(draw_base(two_letter), $urandom_range(0, 149) == 0);
    end
  endtask

  task automatic test_random_settings();
    int               sent;
    int               count;
    logic [CFG_DW-1:0] k_data;
    logic [CFG_DW-1:0] w_data;
    run_phase(6'h1F, 6'h20, 140);
    run_phase(6'h01, 6'h3F, 90);
    run_phase(6'h3F, 6'h01, 80);
    run_phase(6'h00, 6'h21, 90);
    sent = 400;
    while (sent < RANDOM_ITEMS) begin
      k_data = CFG_DW'($urandom_range(0, 1) ? $urandom_range(0, 6) : $urandom_range(0, 63));
      w_data = CFG_DW'($urandom_range(0, 1) ? $urandom_range(0, 6) : $urandom_range(0, 63));
      count  = int'(k_data[KLEN_W-1:0]) + int'(w_data) + int'($urandom_range(20, 70));
      run_phase(k_data, w_data, count);
      sent += count;
    end
  endtask

  // result channel ready: random stall per item, plus the requested hold-off
  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_off_request > 0) begin
        out_ch.ready <= 1'b0;
        repeat (hold_off_request) @(posedge clk);
        hold_off_request = 0;
      end
      stall = receiver_stalls_on ? $urandom_range(0, 3) : 0;
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk);
      while (!(out_ch.valid && out_ch.ready) && hold_off_request == 0);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_minimizers.size() == 0) begin
        $error("unexpected minimizer: value %h, position %0d",
               out_ch.minimizer_value, out_ch.minimizer_position);
        error_count++;
      end else begin
        oldest_expected = expected_minimizers.pop_front();
        if (out_ch.minimizer_value !== oldest_expected.value) begin
          $error("minimizer_value: expected %h, actual %h",
                 oldest_expected.value, out_ch.minimizer_value);
          error_count++;
        end
        if (out_ch.minimizer_position !== oldest_expected.position) begin
          $error("minimizer_position: expected %0d, actual %0d",
                 oldest_expected.position, out_ch.minimizer_position);
          error_count++;
        end
      end
    end
  end

  initial begin
    rst_n                <= 1'b0;
    in_ch.valid          <= 1'b0;
    in_ch.base_char      <= '0;
    in_ch.sequence_start <= 1'b0;
    cfg_we               <= 1'b0;
    cfg_index            <= REG_KMER_LENGTH;
    cfg_wdata            <= '0;
    for (int i = 0; i < MAX_WINDOW; i++) window_hist[i] = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_settings();
    test_base_encoding();
    test_ties_and_restart();
    test_output_holdoff();
    test_random_settings();

    wait_until_drained();
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/ckm_pkg.sv
hdl/ckm_if.sv
hdl/ckm_window_ram.sv
hdl/ckm_kmer_code.sv
hdl/ckm_seq.sv
hdl/canonical_kmer_window_minimizer_core.sv
dv/testbench.sv
